// ===== design/fcte_pkg.sv =====
`default_nettype none
package fcte_pkg;

	// table geometry and values
	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW    = 8;
	localparam int VAL_W     = 14;
	localparam int ADDR_W    = 18;
	localparam int CNT_W     = 9;   // holds counts up to TBL_DEPTH
	localparam int DW        = 21;  // compare/subtract width, spans 256 * 4096

	localparam logic [VAL_W-1:0] FREE_MARK = VAL_W'(9999);

	localparam int FAT_BYTES_DEF   = 512;
	localparam int BLOCK_BYTES_DEF = 512;

	// stream widths
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;

	typedef enum logic [1:0] {
		CMD_FIND = 2'd0,
		CMD_SET  = 2'd1,
		CMD_GET  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_BADADR = 2'd2,
		STAT_LONG   = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		FS_IDLE,
		FS_FF_RD,
		FS_FF_CHK,
		FS_SE_RD,
		FS_SE_CHK,
		FS_SE_WR,
		FS_GL_SUB,
		FS_GL_RNG,
		FS_GL_RD,
		FS_DONE
	} fsm_t;

	typedef struct packed {
		logic              we;
		logic [TBL_AW-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic [TBL_AW-1:0] raddr;
	} tbl_req_t;

	typedef struct packed {
		logic          ge;
		logic [DW-1:0] diff;
	} sub_res_t;

endpackage
`default_nettype wire

// ===== design/fcte_sub.sv =====
`default_nettype none
// shared compare/subtract unit
module fcte_sub (
	input  wire logic [fcte_pkg::DW-1:0] a,
	input  wire logic [fcte_pkg::DW-1:0] b,
	output fcte_pkg::sub_res_t           res
);
	import fcte_pkg::*;

	logic [DW:0] full;

	assign full     = {1'b0, a} - {1'b0, b};
	assign res.ge   = ~full[DW];
	assign res.diff = full[DW-1:0];

endmodule
`default_nettype wire

// ===== design/fcte_tbl.sv =====
`default_nettype none
// chain table: one write and one registered read a cycle.
// per-entry valid bits, an unwritten entry reads free.
module fcte_tbl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire fcte_pkg::tbl_req_t        req,
	output logic [fcte_pkg::VAL_W-1:0]     rdata
);
	import fcte_pkg::*;

	logic [VAL_W-1:0] mem_q [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] valid_q;
	logic [VAL_W-1:0] rd_q;
	logic rvld_q;
	logic byp_q;
	logic [VAL_W-1:0] bypd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_q   <= mem_q[req.raddr];
		rvld_q <= valid_q[req.raddr];
		// write-first on an address clash
		byp_q  <= req.we && (req.waddr == req.raddr);
		bypd_q <= req.wdata;
	end

	assign rdata = byp_q ? bypd_q : (rvld_q ? rd_q : FREE_MARK);

endmodule
`default_nettype wire

// ===== design/fat_chain_table_engine_core.sv =====
`default_nettype none
// find_free reads and checks one entry at a time, up to NUM_BLOCKS entries; set_entry
// reads the entry, frees each link it follows, then writes the new value; get_link
// range-checks the address and reads the block entry, stopping early when it falls
// below/beyond the data area; an unused opcode goes straight to DONE. One command at
// a time, the next word taken once the result is registered; a result still held in
// the output register stalls the sequencer in DONE. Reset clears the table valid bits,
// so every entry reads free at once; a command may be taken right after reset.
module fat_chain_table_engine_core #(
	parameter int FAT_BYTES   = fcte_pkg::FAT_BYTES_DEF,
	parameter int BLOCK_BYTES = fcte_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// block_index[7:0], new_value[21:8], byte_address[39:22]
	input  wire logic [fcte_pkg::S_TDATA_W-1:0]   s_tdata,
	// cmd[1:0]
	input  wire logic [fcte_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// result_value[13:0], zero pad [15:14]
	output logic [fcte_pkg::M_TDATA_W-1:0]        m_tdata,
	// status[1:0]
	output logic [fcte_pkg::M_TUSER_W-1:0]        m_tuser
);
	import fcte_pkg::*;

	// blocks in use: half the table area in bytes, capped by the store
	localparam int NUM_BLOCKS = (FAT_BYTES / 2 < TBL_DEPTH) ? FAT_BYTES / 2 : TBL_DEPTH;
	localparam int SPAN       = NUM_BLOCKS * BLOCK_BYTES;

	localparam logic [CNT_W-1:0] NUM_B  = CNT_W'(NUM_BLOCKS);
	localparam logic [VAL_W-1:0] NUM_V  = VAL_W'(NUM_BLOCKS);
	localparam logic [DW-1:0]    FAT_V  = DW'(FAT_BYTES);
	localparam logic [DW-1:0]    SPAN_V = DW'(SPAN);

	// block number by reciprocal multiply: offset < 2^ADDR_W, so a shift of
	// ADDR_W + clog2(block size) keeps the rounded-up reciprocal exact
	localparam int          RCP_SH = ADDR_W + $clog2(BLOCK_BYTES);
	localparam int          RCP_W  = ADDR_W + 2;
	localparam int          PROD_W = ADDR_W + RCP_W;
	localparam logic [63:0] RCP_M  = ((64'd1 << RCP_SH) + 64'(BLOCK_BYTES) - 64'd1) /
		64'(BLOCK_BYTES);
	localparam logic [RCP_W-1:0] RCP_V = RCP_W'(RCP_M);

	// input word fields
	logic [TBL_AW-1:0] s_idx;
	logic [VAL_W-1:0]  s_nval;
	logic [ADDR_W-1:0] s_addr;
	cmd_t              s_cmd;

	assign s_idx  = s_tdata[7:0];
	assign s_nval = s_tdata[21:8];
	assign s_addr = s_tdata[39:22];
	assign s_cmd  = cmd_t'(s_tuser);

	// sequencer and working registers
	fsm_t st_q, st_d;
	cmd_t cmd_q;
	logic [TBL_AW-1:0] idx_q;
	logic [VAL_W-1:0]  val_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TBL_AW-1:0] ptr_q;     // find_free scan pointer
	logic [CNT_W-1:0]  steps_q;   // links followed so far
	logic [TBL_AW-1:0] prev_q;    // node waiting to be freed
	logic              pend_q;
	logic [DW-1:0]     rem_q;     // byte offset into the data area
	logic [VAL_W-1:0]  res_val_q;
	stat_t             res_st_q;

	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	// datapath links
	tbl_req_t          tbl_req;
	logic [VAL_W-1:0]  rdata;
	logic [DW-1:0]     sub_a, sub_b;
	sub_res_t          sub_res;
	logic              accept;
	logic              done_fire;
	logic              is_link;
	logic              walk_on;
	logic              ptr_last;
	logic [PROD_W-1:0] quo_prod;
	logic [TBL_AW-1:0] quo;

	fcte_tbl u_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rdata  (rdata)
	);

	fcte_sub u_sub (
		.a   (sub_a),
		.b   (sub_b),
		.res (sub_res)
	);

	assign s_tready  = (st_q == FS_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign done_fire = (st_q == FS_DONE) && (!m_tvalid_q || m_tready);

	// a link is a nonzero value that names a block in use (free mark is above any)
	assign is_link  = (rdata != '0) && (rdata < NUM_V);
	assign walk_on  = is_link && (steps_q < NUM_B);
	assign ptr_last = ({1'b0, ptr_q} == NUM_B - CNT_W'(1));
	assign quo_prod = PROD_W'(rem_q[ADDR_W-1:0]) * PROD_W'(RCP_V);
	assign quo      = quo_prod[RCP_SH +: TBL_AW];

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			FS_IDLE: begin
				if (s_tvalid) begin
					case (s_cmd)
						CMD_FIND: st_d = FS_FF_RD;
						CMD_SET:  st_d = FS_SE_RD;
						CMD_GET:  st_d = FS_GL_SUB;
						default:  st_d = FS_DONE;
					endcase
				end
			end
			FS_FF_RD:  st_d = FS_FF_CHK;
			FS_FF_CHK: begin
				if (rdata == FREE_MARK || ptr_last) begin
					st_d = FS_DONE;
				end else begin
					st_d = FS_FF_RD;
				end
			end
			FS_SE_RD:  st_d = FS_SE_CHK;
			FS_SE_CHK: begin
				if (!walk_on) begin
					st_d = FS_SE_WR;
				end
			end
			FS_SE_WR:  st_d = FS_DONE;
			FS_GL_SUB: st_d = sub_res.ge ? FS_GL_RNG : FS_DONE;
			FS_GL_RNG: st_d = sub_res.ge ? FS_DONE : FS_GL_RD;
			FS_GL_RD:  st_d = FS_DONE;
			FS_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					st_d = FS_IDLE;
				end
			end
			default:   st_d = FS_IDLE;
		endcase
	end

	// table port and shared unit operands
	always_comb begin
		tbl_req = '0;
		sub_a   = rem_q;
		sub_b   = SPAN_V;
		case (st_q)
			FS_FF_RD: begin
				tbl_req.raddr = ptr_q;
			end
			FS_SE_RD: begin
				tbl_req.raddr = idx_q;
			end
			FS_SE_CHK: begin
				// free the node just read past, fetch the next one
				tbl_req.we    = pend_q;
				tbl_req.waddr = prev_q;
				tbl_req.wdata = FREE_MARK;
				tbl_req.raddr = rdata[TBL_AW-1:0];
			end
			FS_SE_WR: begin
				tbl_req.we    = 1'b1;
				tbl_req.waddr = idx_q;
				tbl_req.wdata = val_q;
			end
			FS_GL_SUB: begin
				sub_a = DW'(addr_q);
				sub_b = FAT_V;
			end
			FS_GL_RNG: begin
				// range check on the shared unit, block entry fetched alongside
				tbl_req.raddr = quo;
			end
			default: begin
				tbl_req = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= FS_IDLE;
			m_tvalid_q <= 1'b0;
			ptr_q      <= '0;
			steps_q    <= '0;
			pend_q     <= 1'b0;
		end else begin
			st_q <= st_d;
			if (done_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				ptr_q   <= '0;
				steps_q <= '0;
				pend_q  <= 1'b0;
			end
			if (st_q == FS_FF_CHK && rdata != FREE_MARK && !ptr_last) begin
				ptr_q <= ptr_q + TBL_AW'(1);
			end
			if (st_q == FS_SE_CHK) begin
				pend_q <= walk_on;
				if (walk_on) begin
					steps_q <= steps_q + CNT_W'(1);
				end
			end
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= s_cmd;
			idx_q     <= s_idx;
			val_q     <= (s_nval > FREE_MARK) ? FREE_MARK : s_nval;
			addr_q    <= s_addr;
			res_val_q <= '0;
			res_st_q  <= STAT_OK;
		end
		case (st_q)
			FS_FF_CHK: begin
				if (rdata == FREE_MARK) begin
					res_val_q <= VAL_W'(ptr_q);
				end else if (ptr_last) begin
					res_st_q <= STAT_NOFREE;
				end
			end
			FS_SE_CHK: begin
				if (walk_on) begin
					prev_q <= rdata[TBL_AW-1:0];
				end else if (is_link) begin
					res_st_q <= STAT_LONG;
				end
			end
			FS_GL_SUB: begin
				if (sub_res.ge) begin
					rem_q <= sub_res.diff;
				end else begin
					res_st_q <= STAT_BADADR;
				end
			end
			FS_GL_RNG: begin
				if (sub_res.ge) begin
					res_st_q <= STAT_BADADR;
				end
			end
			FS_GL_RD: begin
				res_val_q <= rdata;
			end
			default: begin
			end
		endcase
		if (done_fire) begin
			m_tdata_q <= M_TDATA_W'(res_val_q);
			m_tuser_q <= res_st_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef ASSERT_OFF
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= NUM_B)
		else $error("chain walk step count beyond block count");

	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.we |-> !accept)
		else $error("table written while a command is taken");

	a_long_only_set: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && res_st_q == STAT_LONG) |-> (cmd_q == CMD_SET))
		else $error("chain-too-long status from a command other than set_entry");

	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata != '0) |-> (m_tuser == STAT_OK))
		else $error("nonzero result value with an error status");
`endif

endmodule
`default_nettype wire

// ===== tb/fat_table_checker.sv =====
`default_nettype none
// Watches both stream channels of the table engine, keeps its own copy of the
// allocation table and checks every result word against the predicted one.
module fat_table_checker #(
	parameter int FAT_BYTES   = fcte_pkg::FAT_BYTES_DEF,
	parameter int BLOCK_BYTES = fcte_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [fcte_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [fcte_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [fcte_pkg::M_TDATA_W-1:0] m_tdata,
	input  wire logic [fcte_pkg::M_TUSER_W-1:0] m_tuser,
	output int                               mismatches,
	output int                               awaiting,
	output int                               replies_seen,
	output int                               nofree_seen,
	output int                               badaddr_seen,
	output int                               longest_walk
);
	timeunit 1ns;
	timeprecision 1ps;
	import fcte_pkg::*;

	// entries in use: bounds the free scan, the links followed and the walk length
	localparam int TBL_USED = (FAT_BYTES / 2 < TBL_DEPTH) ? FAT_BYTES / 2 : TBL_DEPTH;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		stat_t            status;
	} fat_reply_t;

	logic [VAL_W-1:0] fat_tbl [TBL_DEPTH];
	fat_reply_t       reply_q [$];
	fat_reply_t       want;
	int               walk_len;

	function automatic fat_reply_t fat_execute(input cmd_t op, input logic [TBL_AW-1:0] idx,
			input logic [VAL_W-1:0] val, input logic [ADDR_W-1:0] addr);
		fat_reply_t       r;
		logic [VAL_W-1:0] cur;
		logic [VAL_W-1:0] nxt;
		int               blk;
		r.value  = '0;
		r.status = STAT_OK;
		walk_len = 0;
		case (op)
		CMD_FIND: begin
			// scan downwards so the last hit is the lowest free entry
			r.status = STAT_NOFREE;
			for (int i = TBL_USED - 1; i >= 0; i--) begin
				if (fat_tbl[i] == FREE_MARK) begin
					r.value  = VAL_W'(i);
					r.status = STAT_OK;
				end
			end
		end
		CMD_SET: begin
			cur = fat_tbl[idx];
			while (cur != '0 && cur != FREE_MARK && int'(cur) < TBL_USED &&
					r.status != STAT_LONG) begin
				if (walk_len >= TBL_USED) begin
					r.status = STAT_LONG;
				end else begin
					nxt = fat_tbl[cur[TBL_AW-1:0]];
					fat_tbl[cur[TBL_AW-1:0]] = FREE_MARK;
					cur = nxt;
					walk_len++;
				end
			end
			fat_tbl[idx] = (val > FREE_MARK) ? FREE_MARK : val;
		end
		CMD_GET: begin
			if (int'(addr) < FAT_BYTES) begin
				r.status = STAT_BADADR;
			end else begin
				blk = (int'(addr) - FAT_BYTES) / BLOCK_BYTES;
				if (blk >= TBL_USED)
					r.status = STAT_BADADR;
				else
					r.value = fat_tbl[blk];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TBL_DEPTH; i++)
				fat_tbl[i] = FREE_MARK;
			reply_q.delete();
			mismatches   = 0;
			awaiting     = 0;
			replies_seen = 0;
			nofree_seen  = 0;
			badaddr_seen = 0;
			longest_walk = 0;
		end else begin
			// a result word always belongs to an earlier command: pop before push
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					$error("result word with nothing expected: value %0d status %0d",
						m_tdata[VAL_W-1:0], m_tuser);
					mismatches++;
				end else begin
					want = reply_q.pop_front();
					replies_seen++;
					if (want.status == STAT_NOFREE) nofree_seen++;
					if (want.status == STAT_BADADR) badaddr_seen++;
					if (m_tdata[VAL_W-1:0] !== want.value) begin
						$error("result_value: expected %0d, got %0d", want.value,
							m_tdata[VAL_W-1:0]);
						mismatches++;
					end
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						mismatches++;
					end
					if (m_tdata[M_TDATA_W-1:VAL_W] !== '0) begin
						$error("pad: expected 0, got %0d", m_tdata[M_TDATA_W-1:VAL_W]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				reply_q.push_back(fat_execute(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[21:8],
					s_tdata[39:22]));
				if (walk_len > longest_walk) longest_walk = walk_len;
			end
			awaiting = reply_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_fat_chain_table_engine_core.sv =====
`default_nettype none
// Stimulus and verdict for the table engine. The checker beside the block owns
// prediction and comparison; this module only drives words and decides the end.
module tb_fat_chain_table_engine_core;
	timeunit 1ns;
	timeprecision 1ps;
	import fcte_pkg::*;

	localparam int FAT_BYTES   = FAT_BYTES_DEF;
	localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;
	// worst case is a full 256-entry scan per word behind heavy stalls; several times over
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PHASE_WORDS = 230;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	int mismatches, awaiting, replies_seen, nofree_seen, badaddr_seen, longest_walk;

	// idling knobs, in percent, per phase: none, sender gaps, receiver stalls, both
	int src_gap_pct [4] = '{0, 77, 0, 14};
	int sink_hold_pct [4] = '{0, 0, 77, 14};
	int src_idle_pct  = 0;
	int sink_stall_pct = 0;

	// long receiver hold-off: stimulus requests it, the receiver process counts it down
	int pause_len  = 0;
	int pause_left = 0;

	int cycles = 0;
	int words_sent = 0;
	int n_find = 0, n_set = 0, n_get = 0, n_nop = 0;

	fat_chain_table_engine_core #(
		.FAT_BYTES   (FAT_BYTES),
		.BLOCK_BYTES (BLOCK_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	fat_table_checker #(
		.FAT_BYTES   (FAT_BYTES),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.mismatches   (mismatches),
		.awaiting     (awaiting),
		.replies_seen (replies_seen),
		.nofree_seen  (nofree_seen),
		.badaddr_seen (badaddr_seen),
		.longest_walk (longest_walk)
	);

	always #1 clk = ~clk;

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (pause_len > 0) begin
			pause_left = pause_len;
			pause_len  = 0;
		end
		if (pause_left > 0) begin
			pause_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, awaiting);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Drive one command word; called and returns at a falling edge. Valid is only
	// touched once per edge, so back-to-back words keep it high.
	task automatic issue_cmd(input cmd_t op, input logic [TBL_AW-1:0] idx,
			input logic [VAL_W-1:0] val, input logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {addr, val, idx};   // byte_address | new_value | block_index
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		words_sent++;
		case (op)
		CMD_FIND: n_find++;
		CMD_SET:  n_set++;
		CMD_GET:  n_get++;
		default:  n_nop++;
		endcase
	endtask

	// new_value mix: mostly in-table links, then ends, frees, links past the
	// table and values that must saturate to free
	function automatic logic [VAL_W-1:0] pick_value();
		int               r;
		logic [VAL_W-1:0] v;
		r = $urandom_range(99);
		if (r < 50)      v = VAL_W'($urandom_range(1, 255));
		else if (r < 65) v = '0;
		else if (r < 80) v = FREE_MARK;
		else if (r < 90) v = VAL_W'($urandom_range(256, 9998));
		else             v = VAL_W'($urandom_range(10000, 16383));
		return v;
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		int                r;
		logic [ADDR_W-1:0] a;
		r = $urandom_range(99);
		if (r < 70)      a = ADDR_W'($urandom_range(FAT_BYTES, FAT_BYTES + 256 * BLOCK_BYTES - 1));
		else if (r < 80) a = ADDR_W'($urandom_range(0, FAT_BYTES - 1));
		else             a = ADDR_W'($urandom_range(FAT_BYTES + 256 * BLOCK_BYTES, 262143));
		return a;
	endfunction

	// any byte inside data block b
	function automatic logic [ADDR_W-1:0] block_addr(input int b);
		return ADDR_W'(FAT_BYTES + b * BLOCK_BYTES + $urandom_range(BLOCK_BYTES - 1));
	endfunction

	// Mostly well-formed file work: build a chain, read its links back, then
	// often overwrite the head so the engine walks and frees it.
	task automatic random_phase(input int n_words);
		int start;
		int pick;
		int len;
		int chain_blk [8];
		logic [VAL_W-1:0] nxt;
		start = words_sent;
		while (words_sent - start < n_words) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				len = $urandom_range(1, 8);
				chain_blk[0] = $urandom_range(0, 255);
				for (int k = 1; k < len; k++)
					chain_blk[k] = $urandom_range(1, 255);   // 0 would read as end of chain
				for (int k = 0; k < len; k++) begin
					if (k < len - 1)
						nxt = VAL_W'(chain_blk[k + 1]);
					else
						nxt = ($urandom_range(9) == 0) ? FREE_MARK : '0;
					issue_cmd(CMD_SET, TBL_AW'(chain_blk[k]), nxt, ADDR_W'($urandom));
				end
				for (int k = 0; k < len; k++)
					issue_cmd(CMD_GET, TBL_AW'($urandom), VAL_W'($urandom),
						block_addr(chain_blk[k]));
				if ($urandom_range(1))
					issue_cmd(CMD_SET, TBL_AW'(chain_blk[0]), pick_value(), ADDR_W'($urandom));
			end else if (pick < 55) begin
				repeat ($urandom_range(1, 2))
					issue_cmd(CMD_FIND, TBL_AW'($urandom), VAL_W'($urandom), ADDR_W'($urandom));
			end else if (pick < 70) begin
				issue_cmd(CMD_GET, TBL_AW'($urandom), VAL_W'($urandom), pick_addr());
			end else if (pick < 85) begin
				issue_cmd(CMD_SET, TBL_AW'($urandom), pick_value(), ADDR_W'($urandom));
			end else begin
				// noise: any opcode, every field fully random
				issue_cmd(cmd_t'($urandom_range(3)), TBL_AW'($urandom), VAL_W'($urandom),
					ADDR_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ---- directed ----
		issue_cmd(CMD_FIND, '0, '0, '0);                      // empty table: block 0
		issue_cmd(CMD_GET, '0, '0, ADDR_W'(0));               // inside table area
		issue_cmd(CMD_GET, '0, '0, ADDR_W'(FAT_BYTES - 1));   // last byte of table area
		issue_cmd(CMD_GET, '0, '0, ADDR_W'(FAT_BYTES));       // first data block
		issue_cmd(CMD_GET, '0, '0, ADDR_W'(131583));          // last byte of last block
		issue_cmd(CMD_GET, '0, '0, ADDR_W'(131584));          // one block past the table
		issue_cmd(CMD_GET, '0, '0, '1);                       // top of address space
		issue_cmd(CMD_SET, TBL_AW'(0), VAL_W'(1), '0);
		issue_cmd(CMD_SET, TBL_AW'(1), VAL_W'(2), '0);
		issue_cmd(CMD_SET, TBL_AW'(2), VAL_W'(300), '0);      // link past the table ends it
		issue_cmd(CMD_FIND, '0, '0, '0);                      // first free now 3
		issue_cmd(CMD_GET, '0, '0, ADDR_W'(FAT_BYTES + BLOCK_BYTES));
		issue_cmd(CMD_SET, TBL_AW'(0), '1, '0);               // saturates to free, frees 1 and 2
		issue_cmd(CMD_GET, '0, '0, ADDR_W'(FAT_BYTES));
		issue_cmd(CMD_FIND, '0, '0, '0);
		issue_cmd(CMD_SET, TBL_AW'(200), '0, '0);
		issue_cmd(CMD_SET, TBL_AW'(255), VAL_W'(200), '0);
		issue_cmd(CMD_SET, TBL_AW'(255), FREE_MARK, '0);      // frees 200
		issue_cmd(CMD_GET, '0, '0, ADDR_W'(FAT_BYTES + 200 * BLOCK_BYTES));
		issue_cmd(CMD_SET, TBL_AW'(7), VAL_W'(9998), '0);     // largest non-free value
		issue_cmd(CMD_SET, TBL_AW'(7), '0, '0);               // 9998 is no link: nothing freed
		issue_cmd(CMD_NOP, '1, '1, '1);                       // unused opcode

		// ---- fill: one long ring 1..255 plus entry 0, so nothing is free ----
		// the directed part left no links behind, so no entry is freed on the way
		src_idle_pct   = src_gap_pct[3];
		sink_stall_pct = sink_hold_pct[3];
		issue_cmd(CMD_SET, TBL_AW'(0), '0, ADDR_W'($urandom));
		for (int i = 1; i < 255; i++)
			issue_cmd(CMD_SET, TBL_AW'(i), VAL_W'(i + 1), ADDR_W'($urandom));
		issue_cmd(CMD_SET, TBL_AW'(255), VAL_W'(1), ADDR_W'($urandom));   // closes the ring
		issue_cmd(CMD_FIND, '0, '0, '0);                      // no free block
		issue_cmd(CMD_GET, '0, '0, block_addr(255));
		issue_cmd(CMD_SET, TBL_AW'(1), '0, '0);               // walk frees the whole ring
		issue_cmd(CMD_FIND, '0, '0, '0);

		// ---- random phases ----
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct   = src_gap_pct[ph];
			sink_stall_pct = sink_hold_pct[ph];
			// sender keeps offering while the receiver is held off: input must stall
			if (ph == 0) pause_len = 300;
			random_phase(PHASE_WORDS);
		end
		s_tvalid <= 1'b0;

		// drain, then a short tail for any stray word
		while (awaiting != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("sent %0d words: %0d find_free, %0d set_entry, %0d get_link, %0d unused",
			words_sent, n_find, n_set, n_get, n_nop);
		$display("checked %0d results (%0d no free block, %0d bad address), longest walk %0d",
			replies_seen, nofree_seen, badaddr_seen, longest_walk);
		if (mismatches == 0 && awaiting == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire
